// ===== sv/replacement_selection_runs_assert.svh =====
// assertion macros for the run generator
`ifndef REPLACEMENT_SELECTION_RUNS_ASSERT_SVH
`define REPLACEMENT_SELECTION_RUNS_ASSERT_SVH

`ifndef SYNTH
`define RSR_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define RSR_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("assertion failed");
`else
`define RSR_ASSERT(lbl, clk, rst, prop)
`define RSR_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== sv/rsr_pkg.sv =====
`default_nettype none
package rsr_pkg;
   localparam int WORKSPACE = 8;
   localparam int KEY_WIDTH = 32;
   localparam int IDX_W = (WORKSPACE > 1) ? $clog2(WORKSPACE) : 1;
   localparam int CNT_W = $clog2(WORKSPACE + 1);
   localparam logic [15:0] RUN_MAX = 16'hFFFF;

   typedef logic signed [KEY_WIDTH-1:0] key_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic             fill_write;
      logic             scan_clear;
      logic             scan_step;
      logic [IDX_W-1:0] scan_idx;
      logic             replace;
      logic             drain_take;
   } cmd_type;

   typedef struct packed {
      logic fill_full;
      logic found;
      logic drain_last;
   } sts_type;

   function automatic key_type to_key(input logic signed [31:0] v);
      return key_type'(v);
   endfunction

   function automatic logic signed [31:0] from_key(input key_type k);
      return 32'(k);
   endfunction
endpackage
`default_nettype wire

// ===== sv/rsr_req_if.sv =====
`default_nettype none
interface rsr_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] record_value;
   logic               end_of_input;
   modport source (output valid, record_value, end_of_input, input ready);
   modport sink (input valid, record_value, end_of_input, output ready);
endinterface
`default_nettype wire

// ===== sv/rsr_rsp_if.sv =====
`default_nettype none
interface rsr_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] out_value;
   logic [15:0]        run_index;
   logic               run_last;
   logic               stream_last;
   modport source (output valid, out_value, run_index, run_last, stream_last, input ready);
   modport sink (input valid, out_value, run_index, run_last, stream_last, output ready);
endinterface
`default_nettype wire

// ===== sv/rsr_datapath.sv =====
`default_nettype none
module rsr_datapath (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire rsr_pkg::cmd_type   cmd,
   output rsr_pkg::sts_type        sts,
   input  wire logic signed [31:0] in_value,
   output logic signed [31:0]      out_value,
   output logic [15:0]             run_index,
   output logic                    run_last,
   output logic                    stream_last
);
   rsr_pkg::key_type                   keys_ff [rsr_pkg::WORKSPACE];
   rsr_pkg::key_type                   keys_in [rsr_pkg::WORKSPACE];
   logic [rsr_pkg::WORKSPACE-1:0]      tag_ff, tag_in, valid_ff, valid_in;
   logic [rsr_pkg::CNT_W-1:0]          fill_ff, fill_in;
   logic [15:0]                        run_ff, run_in;
   logic [rsr_pkg::IDX_W-1:0]          best_idx_ff, best_idx_in;
   rsr_pkg::key_type                   best_key_ff, best_key_in;
   rsr_pkg::key_type                   in_key_ff, in_key_in;
   logic                               best_tag_ff, best_tag_in, found_ff, found_in;
   logic signed [31:0]                 oval_ff, oval_in;
   logic [15:0]                        orun_ff, orun_in;
   logic                               orl_ff, orl_in, osl_ff, osl_in;
   rsr_pkg::key_type                   e_key;
   logic                               e_tag, e_less, new_tag, rl, sl;
   logic [rsr_pkg::WORKSPACE-1:0]      others, cur_others;
   logic [15:0]                        run_next;

   assign e_key = keys_ff[cmd.scan_idx];
   assign e_tag = tag_ff[cmd.scan_idx];
   assign e_less = !found_ff || (!e_tag && best_tag_ff) ||
                   (e_tag == best_tag_ff && e_key < best_key_ff);
   assign new_tag = in_key_ff < best_key_ff;
   assign run_next = (run_ff == rsr_pkg::RUN_MAX) ? run_ff : run_ff + 16'd1;

   always_comb begin
      others = valid_ff;
      others[best_idx_ff] = 1'b0;
      cur_others = others & ~tag_ff;
   end

   assign sl = ~|others;

   always_comb begin
      keys_in = keys_ff;
      tag_in = tag_ff;
      valid_in = valid_ff;
      fill_in = fill_ff;
      run_in = run_ff;
      best_idx_in = best_idx_ff;
      best_key_in = best_key_ff;
      best_tag_in = best_tag_ff;
      found_in = found_ff;
      in_key_in = in_key_ff;
      oval_in = oval_ff;
      orun_in = orun_ff;
      orl_in = orl_ff;
      osl_in = osl_ff;
      rl = 1'b0;
      if (cmd.fill_write || cmd.scan_clear && !cmd.replace && !cmd.drain_take)
         in_key_in = rsr_pkg::to_key(in_value);
      if (cmd.fill_write) begin
         keys_in[fill_ff[rsr_pkg::IDX_W-1:0]] = rsr_pkg::to_key(in_value);
         tag_in[fill_ff[rsr_pkg::IDX_W-1:0]] = 1'b0;
         valid_in[fill_ff[rsr_pkg::IDX_W-1:0]] = 1'b1;
         fill_in = fill_ff + rsr_pkg::CNT_W'(1);
      end
      if (cmd.scan_clear)
         found_in = 1'b0;
      if (cmd.scan_step && valid_ff[cmd.scan_idx] && e_less) begin
         found_in = 1'b1;
         best_idx_in = cmd.scan_idx;
         best_key_in = e_key;
         best_tag_in = e_tag;
      end
      if (cmd.replace) begin
         // current run ends when nothing untagged is left after the swap
         rl = ~|cur_others && new_tag;
         keys_in[best_idx_ff] = in_key_ff;
         tag_in[best_idx_ff] = new_tag;
         oval_in = rsr_pkg::from_key(best_key_ff);
         orun_in = run_ff;
         orl_in = rl;
         osl_in = 1'b0;
         if (rl) begin
            run_in = run_next;
            tag_in = '0;
         end
      end
      if (cmd.drain_take) begin
         rl = sl || ~|cur_others;
         oval_in = rsr_pkg::from_key(best_key_ff);
         orun_in = run_ff;
         orl_in = rl;
         osl_in = sl;
         valid_in[best_idx_ff] = 1'b0;
         if (sl) begin
            valid_in = '0;
            tag_in = '0;
            fill_in = '0;
            run_in = 16'd1;
         end else if (rl) begin
            run_in = run_next;
            tag_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
         valid_ff <= '0;
         fill_ff <= '0;
         run_ff <= 16'd1;
         found_ff <= 1'b0;
      end else begin
         tag_ff <= tag_in;
         valid_ff <= valid_in;
         fill_ff <= fill_in;
         run_ff <= run_in;
         found_ff <= found_in;
      end
      keys_ff <= keys_in;
      best_idx_ff <= best_idx_in;
      best_key_ff <= best_key_in;
      best_tag_ff <= best_tag_in;
      in_key_ff <= in_key_in;
      oval_ff <= oval_in;
      orun_ff <= orun_in;
      orl_ff <= orl_in;
      osl_ff <= osl_in;
   end

   assign sts.fill_full = fill_ff == rsr_pkg::CNT_W'(rsr_pkg::WORKSPACE);
   assign sts.found = found_ff;
   assign sts.drain_last = sl;
   assign out_value = oval_ff;
   assign run_index = orun_ff;
   assign run_last = orl_ff;
   assign stream_last = osl_ff;
endmodule
`default_nettype wire

// ===== sv/rsr_control.sv =====
`default_nettype none
`include "replacement_selection_runs_assert.svh"
module rsr_control (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic             req_end,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output rsr_pkg::cmd_type      cmd,
   input  wire rsr_pkg::sts_type sts
);
   rsr_pkg::state_type         state_ff, state_in;
   logic [rsr_pkg::IDX_W-1:0]  idx_ff, idx_in;
   logic                       drain_ff, drain_in, end_ff, end_in;
   logic                       rspv_ff, rspv_in, slot_free, idx_last;

   assign slot_free = !rspv_ff || rsp_ready;
   assign idx_last = idx_ff == rsr_pkg::IDX_W'(rsr_pkg::WORKSPACE - 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rsr_pkg::ST_IDLE;
         idx_ff <= '0;
         drain_ff <= 1'b0;
         end_ff <= 1'b0;
         rspv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         drain_ff <= drain_in;
         end_ff <= end_in;
         rspv_ff <= rspv_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      drain_in = drain_ff;
      end_in = end_ff;
      rspv_in = rspv_ff && !rsp_ready;
      cmd = '0;
      cmd.scan_idx = idx_ff;
      req_ready = 1'b0;
      case (state_ff)
         rsr_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               end_in = req_end;
               idx_in = '0;
               if (!sts.fill_full) begin
                  cmd.fill_write = 1'b1;
                  if (req_end) begin
                     drain_in = 1'b1;
                     cmd.scan_clear = 1'b1;
                     state_in = rsr_pkg::ST_SCAN;
                  end
               end else begin
                  cmd.scan_clear = 1'b1;
                  drain_in = 1'b0;
                  state_in = rsr_pkg::ST_SCAN;
               end
            end
         end
         rsr_pkg::ST_SCAN: begin
            cmd.scan_step = 1'b1;
            idx_in = idx_ff + rsr_pkg::IDX_W'(1);
            if (idx_last) begin
               idx_in = '0;
               state_in = rsr_pkg::ST_EMIT;
            end
         end
         rsr_pkg::ST_EMIT: begin
            if (slot_free) begin
               rspv_in = 1'b1;
               if (drain_ff) begin
                  cmd.drain_take = 1'b1;
                  if (sts.drain_last) begin
                     drain_in = 1'b0;
                     state_in = rsr_pkg::ST_IDLE;
                  end else begin
                     cmd.scan_clear = 1'b1;
                     state_in = rsr_pkg::ST_SCAN;
                  end
               end else begin
                  cmd.replace = 1'b1;
                  if (end_ff) begin
                     drain_in = 1'b1;
                     cmd.scan_clear = 1'b1;
                     state_in = rsr_pkg::ST_SCAN;
                  end else begin
                     state_in = rsr_pkg::ST_IDLE;
                  end
               end
            end
         end
         default: state_in = rsr_pkg::ST_IDLE;
      endcase
   end

   assign rsp_valid = rspv_ff;

   `RSR_ASSERT(a_emit_slot, clock, reset, (cmd.replace || cmd.drain_take) |-> slot_free)
   `RSR_ASSERT(a_emit_found, clock, reset, state_ff == rsr_pkg::ST_EMIT |-> sts.found)
   `RSR_ASSERT(a_scan_start, clock, reset, (state_ff == rsr_pkg::ST_SCAN && $past(state_ff) != rsr_pkg::ST_SCAN) |-> idx_ff == '0)
   `RSR_ASSERT(a_scan_len, clock, reset, (state_ff == rsr_pkg::ST_SCAN && idx_last) |=> state_ff == rsr_pkg::ST_EMIT)
endmodule
`default_nettype wire

// ===== sv/replacement_selection_runs.sv =====
`default_nettype none
// Replacement-selection run generator. The first 8 records fill the workspace and give
// no word; each later record takes a scan of every workspace entry for the winner, one
// compare per cycle, then an emit when the output slot is free, and yields one word.
// An end flag drains the workspace, scan and emit per word, runs marked by run_last and
// the last word by stream_last, then the block is back in reset state for a new stream.
// Results sit in an output register, so a new record is taken while a word waits.
module replacement_selection_runs (
   input wire logic clock,
   input wire logic reset,
   rsr_req_if.sink  req_ch,
   rsr_rsp_if.source rsp_ch
);
   rsr_pkg::cmd_type cmd;
   rsr_pkg::sts_type sts;

   rsr_control u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .req_end   (req_ch.end_of_input),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   rsr_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .in_value    (req_ch.record_value),
      .out_value   (rsp_ch.out_value),
      .run_index   (rsp_ch.run_index),
      .run_last    (rsp_ch.run_last),
      .stream_last (rsp_ch.stream_last)
   );
endmodule
`default_nettype wire

// ===== tb/sv/rsr_stream_checker.sv =====
`default_nettype none
module rsr_stream_checker (
   input wire logic clock,
   input wire logic reset,
   rsr_req_if       req_mon,
   rsr_rsp_if       rsp_mon,
   output int       fail_count,
   output int       words_pending
);
   typedef struct packed {
      logic signed [31:0] out_value;
      logic [15:0]        run_index;
      logic               run_last;
      logic               stream_last;
   } run_word_type;

   rsr_pkg::key_type slot_key [rsr_pkg::WORKSPACE];
   logic             slot_late [rsr_pkg::WORKSPACE];
   logic             slot_used [rsr_pkg::WORKSPACE];
   int               filled;
   logic [15:0]      run_no;
   run_word_type     sorted_words [$];

   function automatic logic slot_below(int a, int b);
      if (slot_late[a] != slot_late[b]) return slot_late[a] < slot_late[b];
      return slot_key[a] < slot_key[b];
   endfunction

   function automatic int winner_slot();
      int w;
      w = rsr_pkg::WORKSPACE;
      for (int i = 0; i < rsr_pkg::WORKSPACE; i++)
         if (slot_used[i] && (w == rsr_pkg::WORKSPACE || slot_below(i, w))) w = i;
      return w;
   endfunction

   function automatic logic run_exhausted();
      for (int i = 0; i < rsr_pkg::WORKSPACE; i++)
         if (slot_used[i] && !slot_late[i]) return 1'b0;
      return 1'b1;
   endfunction

   function automatic logic any_used();
      for (int i = 0; i < rsr_pkg::WORKSPACE; i++)
         if (slot_used[i]) return 1'b1;
      return 1'b0;
   endfunction

   task automatic clear_workspace();
      for (int i = 0; i < rsr_pkg::WORKSPACE; i++) begin
         slot_late[i] = 1'b0;
         slot_used[i] = 1'b0;
      end
      filled = 0;
      run_no = 16'd1;
   endtask

   task automatic next_run();
      if (run_no != rsr_pkg::RUN_MAX) run_no++;
      for (int i = 0; i < rsr_pkg::WORKSPACE; i++) slot_late[i] = 1'b0;
   endtask

   task automatic push_word(rsr_pkg::key_type k, logic rl, logic sl);
      run_word_type wd;
      wd.out_value   = rsr_pkg::from_key(k);
      wd.run_index   = run_no;
      wd.run_last    = rl;
      wd.stream_last = sl;
      sorted_words.push_back(wd);
   endtask

   task automatic take_record(logic signed [31:0] v, logic last);
      int               w;
      rsr_pkg::key_type k, old;
      logic             rl, sl;
      k = rsr_pkg::to_key(v);
      if (filled < rsr_pkg::WORKSPACE) begin
         slot_key[filled]  = k;
         slot_late[filled] = 1'b0;
         slot_used[filled] = 1'b1;
         filled++;
      end else begin
         w = winner_slot();
         old = slot_key[w];
         slot_key[w]  = k;
         slot_late[w] = k < old;
         rl = run_exhausted();
         push_word(old, rl, 1'b0);
         if (rl) next_run();
      end
      if (last) begin
         forever begin
            w = winner_slot();
            if (w == rsr_pkg::WORKSPACE) break;
            slot_used[w] = 1'b0;
            sl = !any_used();
            rl = sl || run_exhausted();
            push_word(slot_key[w], rl, sl);
            if (sl) break;
            if (rl) next_run();
         end
         clear_workspace();
      end
   endtask

   assign words_pending = sorted_words.size();

   always @(posedge clock) begin
      run_word_type got, want;
      if (reset) begin
         clear_workspace();
         sorted_words.delete();
         fail_count <= 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = {rsp_mon.out_value, rsp_mon.run_index, rsp_mon.run_last,
                   rsp_mon.stream_last};
            if (sorted_words.size() == 0) begin
               $display("%0t: unexpected word, expected none, actual %h", $time, got);
               fail_count <= fail_count + 1;
            end else begin
               want = sorted_words.pop_front();
               if (got != want) begin
                  $display({"%0t: mismatch expected val=%0d run=%0d rl=%b sl=%b",
                            " actual val=%0d run=%0d rl=%b sl=%b"},
                     $time, want.out_value, want.run_index, want.run_last, want.stream_last,
                     got.out_value, got.run_index, got.run_last, got.stream_last);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            take_record(req_mon.record_value, req_mon.end_of_input);
      end
   end
endmodule
`default_nettype wire

// ===== tb/sv/replacement_selection_runs_tb.sv =====
`default_nettype none
module replacement_selection_runs_tb;
   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   words_pending;
   int   stall_left;

   rsr_req_if req_ch ();
   rsr_rsp_if rsp_ch ();

   replacement_selection_runs u_top (
      .clock (clock), .reset (reset), .req_ch (req_ch.sink), .rsp_ch (rsp_ch.source)
   );

   rsr_stream_checker u_check (
      .clock (clock), .reset (reset), .req_mon (req_ch), .rsp_mon (rsp_ch),
      .fail_count (fail_count), .words_pending (words_pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // sink side: random stall per word, with quiet stretches
   always @(posedge clock) begin
      int wait_len;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left <= 0;
      end else if (rsp_ch.valid && rsp_ch.ready) begin
         wait_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
         rsp_ch.ready <= (wait_len == 0);
         stall_left <= (wait_len > 0) ? wait_len - 1 : 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   function automatic logic signed [31:0] pick_key(int shape);
      case (shape)
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         2: return 32'($urandom_range(0, 15)) - 32'sd8;
         default: return $signed($urandom());
      endcase
   endfunction

   task automatic send_record(logic signed [31:0] v, logic last, bit gaps);
      int gap;
      gap = gaps ? $urandom_range(0, 11) : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.record_value <= v;
      req_ch.end_of_input <= last;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   initial begin
      int len;
      int shape;
      bit gaps;
      req_ch.valid = 1'b0;
      req_ch.record_value = '0;
      req_ch.end_of_input = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: short stream, extremes and ties, then a falling run change
      send_record(32'sh7fff_ffff, 1'b0, 1'b0);
      send_record(32'sh8000_0000, 1'b0, 1'b0);
      send_record(32'sd5, 1'b1, 1'b0);
      send_record(32'sd3, 1'b1, 1'b1);
      for (int i = 0; i < 8; i++) send_record(32'sd10 * i, 1'b0, 1'b1);
      send_record(32'sd0, 1'b0, 1'b1);
      send_record(32'sd0, 1'b0, 1'b1);
      send_record(32'sh8000_0000, 1'b0, 1'b1);
      send_record(32'sh7fff_ffff, 1'b0, 1'b1);
      send_record(-32'sd1, 1'b0, 1'b1);
      send_record(32'sh8000_0000, 1'b1, 1'b1);
      for (int i = 0; i < 9; i++) send_record(32'sd100 - 32'sd10 * i, i == 8, 1'b1);

      // random streams of varied length
      for (int n = 0; n < 200;) begin
         len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 8) : $urandom_range(9, 40);
         shape = $urandom_range(0, 3);
         gaps = $urandom_range(0, 4) != 0;
         for (int i = 0; i < len; i++) begin
            send_record((shape == 2 || $urandom_range(0, 9) == 0) ?
                        pick_key($urandom_range(0, 2)) : pick_key(3), i == len - 1, gaps);
            n++;
         end
      end
      req_ch.valid <= 1'b0;

      while (words_pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (fail_count == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

   initial begin
      #3000000;
      $display("status: fail");
      $finish;
   end
endmodule
`default_nettype wire
